// ===== sv/mwbm_pkg.sv =====
// Shared types, codes and constants for the max-weight bipartite matching unit.
package mwbm_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int WEIGHT_BITS_DEF  = 16;
    localparam int LABEL_BITS       = 32;
    localparam int SLACK_BITS       = 34;
    localparam logic signed [SLACK_BITS-1:0] SLACK_START = 34'sh03f3f3f3f;
    localparam int SIZE_BITS        = 5;
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 5'd16;
    localparam int FIELD_IDX_BITS   = 4;
    localparam int PAIR_BITS        = 16;
    localparam int TOTAL_BITS       = 20;
    localparam int IN_TDATA_BITS    = 24;
    localparam int OUT_TDATA_BITS   = 48;

    typedef logic [4:0] op_t;

    localparam op_t OP_NOP       = 5'd0;
    localparam op_t OP_LOAD      = 5'd1;
    localparam op_t OP_START     = 5'd2;
    localparam op_t OP_INIT_RD   = 5'd3;
    localparam op_t OP_INIT_EV   = 5'd4;
    localparam op_t OP_ROOT      = 5'd5;
    localparam op_t OP_NEXTY     = 5'd6;
    localparam op_t OP_SCAN_RD   = 5'd7;
    localparam op_t OP_EVAL      = 5'd8;
    localparam op_t OP_POP       = 5'd9;
    localparam op_t OP_AUG       = 5'd10;
    localparam op_t OP_NEXT_ROOT = 5'd11;
    localparam op_t OP_SH_START  = 5'd12;
    localparam op_t OP_SH_RD     = 5'd13;
    localparam op_t OP_SH_EV     = 5'd14;
    localparam op_t OP_SH_APPLY  = 5'd15;
    localparam op_t OP_OUT_RD    = 5'd16;
    localparam op_t OP_OUT_EV    = 5'd17;

    typedef struct packed {
        logic y_end;
        logic y_seen;
        logic eq;
        logic free;
        logic depth_one;
        logic k_last;
        logic root_last;
        logic col_last;
        logic mat_last;
        logic out_free;
    } status_t;

endpackage

// ===== sv/mwbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mwbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/mwbm_ctrl.sv =====
// Controller state machine sequencing load, label init, path search, label shift and output.
module mwbm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tuser,
    output logic              s_tready,
    input  mwbm_pkg::status_t status,
    output mwbm_pkg::op_t     op
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_INIT_RD   = 4'd1;
    localparam logic [3:0] S_INIT_EV   = 4'd2;
    localparam logic [3:0] S_ROOT      = 4'd3;
    localparam logic [3:0] S_SCAN_RD   = 4'd4;
    localparam logic [3:0] S_SCAN_EV   = 4'd5;
    localparam logic [3:0] S_AUG       = 4'd6;
    localparam logic [3:0] S_NEXT_ROOT = 4'd7;
    localparam logic [3:0] S_SH_START  = 4'd8;
    localparam logic [3:0] S_SH_RD     = 4'd9;
    localparam logic [3:0] S_SH_EV     = 4'd10;
    localparam logic [3:0] S_SH_APPLY  = 4'd11;
    localparam logic [3:0] S_OUT_RD    = 4'd12;
    localparam logic [3:0] S_OUT_EV    = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op         = mwbm_pkg::OP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        op         = mwbm_pkg::OP_START;
                        state_next = S_INIT_RD;
                    end
                    else
                    begin
                        op = mwbm_pkg::OP_LOAD;
                    end
                end
            end
            S_INIT_RD:
            begin
                op         = mwbm_pkg::OP_INIT_RD;
                state_next = S_INIT_EV;
            end
            S_INIT_EV:
            begin
                op         = mwbm_pkg::OP_INIT_EV;
                state_next = status.mat_last ? S_ROOT : S_INIT_RD;
            end
            S_ROOT:
            begin
                op         = mwbm_pkg::OP_ROOT;
                state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                priority if (status.y_end)
                begin
                    op         = mwbm_pkg::OP_POP;
                    state_next = status.depth_one ? S_SH_START : S_SCAN_RD;
                end
                else if (status.y_seen)
                begin
                    op = mwbm_pkg::OP_NEXTY;
                end
                else
                begin
                    op         = mwbm_pkg::OP_SCAN_RD;
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                op         = mwbm_pkg::OP_EVAL;
                state_next = (status.eq && status.free) ? S_AUG : S_SCAN_RD;
            end
            S_AUG:
            begin
                op = mwbm_pkg::OP_AUG;
                if (status.k_last)
                begin
                    state_next = S_NEXT_ROOT;
                end
            end
            S_NEXT_ROOT:
            begin
                op         = mwbm_pkg::OP_NEXT_ROOT;
                state_next = status.root_last ? S_OUT_RD : S_ROOT;
            end
            S_SH_START:
            begin
                op         = mwbm_pkg::OP_SH_START;
                state_next = S_SH_RD;
            end
            S_SH_RD:
            begin
                op         = mwbm_pkg::OP_SH_RD;
                state_next = S_SH_EV;
            end
            S_SH_EV:
            begin
                op         = mwbm_pkg::OP_SH_EV;
                state_next = status.mat_last ? S_SH_APPLY : S_SH_RD;
            end
            S_SH_APPLY:
            begin
                op         = mwbm_pkg::OP_SH_APPLY;
                state_next = S_ROOT;
            end
            S_OUT_RD:
            begin
                op         = mwbm_pkg::OP_OUT_RD;
                state_next = S_OUT_EV;
            end
            S_OUT_EV:
            begin
                if (status.out_free)
                begin
                    op         = mwbm_pkg::OP_OUT_EV;
                    state_next = status.col_last ? S_IDLE : S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/mwbm_datapath.sv =====
// Datapath: weight store, labels, match table, search stack, slack minimum and result register.
module mwbm_datapath #(
    parameter int MAX_VERTICES = mwbm_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = mwbm_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mwbm_pkg::op_t                       op,
    output mwbm_pkg::status_t                   status,
    input  logic [mwbm_pkg::IN_TDATA_BITS-1:0]  s_tdata,
    input  logic                                cfg_we,
    input  logic [mwbm_pkg::SIZE_BITS-1:0]      cfg_wdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mwbm_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int LB    = mwbm_pkg::LABEL_BITS;
    localparam int SB    = mwbm_pkg::SLACK_BITS;
    localparam int TB    = mwbm_pkg::TOTAL_BITS;
    localparam int FB    = mwbm_pkg::FIELD_IDX_BITS;

    logic [mwbm_pkg::SIZE_BITS-1:0] size_reg;
    logic [CNT_W-1:0]               n_reg;
    logic [IDX_W-1:0]               r_reg, c_reg, x_reg, root_reg, k_reg;
    logic [CNT_W-1:0]               y_reg, depth_reg;
    logic signed [LB-1:0]           max_reg;
    logic signed [SB-1:0]           d_reg;
    logic signed [TB-1:0]           total_reg;
    logic signed [LB-1:0]           lx_reg [MAX_VERTICES];
    logic signed [LB-1:0]           ly_reg [MAX_VERTICES];
    logic [CNT_W-1:0]               partner_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]        lseen_reg, rseen_reg;
    logic [IDX_W-1:0]               stack_reg [MAX_VERTICES];
    logic [IDX_W-1:0]               scan_reg [MAX_VERTICES];
    logic                           out_valid_reg;
    logic [mwbm_pkg::OUT_TDATA_BITS-1:0] out_data_reg;
    logic                           out_user_reg, out_last_reg;

    logic [FB-1:0]                  ld_row, ld_col;
    logic [mwbm_pkg::PAIR_BITS-1:0] ld_weight;
    logic signed [31:0]             ld_wide;
    logic                           ld_ok;
    logic [AW-1:0]                  waddr, raddr;
    logic                           ram_we, ram_re;
    logic signed [WEIGHT_BITS-1:0]  rdata;
    logic signed [LB-1:0]           w_ext, max_new, pw;
    logic [CNT_W-1:0]               n_cfg;
    logic                           rc_mode;
    logic [IDX_W-1:0]               lsel, rsel, sidx, tidx, didx, nx;
    logic [CNT_W-1:0]               partner_cur;
    logic [IDX_W-1:0]               stack_rd, scan_rd;
    logic signed [LB:0]             lsum;
    logic signed [SB-1:0]           slack;
    logic signed [TB-1:0]           total_new;
    logic                           pmatch;

    function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] rr,
                                              input logic [IDX_W-1:0] cc);
        addr_of = AW'(AW'(rr) * AW'(MAX_VERTICES) + AW'(cc));
    endfunction

    assign ld_row    = s_tdata[FB-1:0];
    assign ld_col    = s_tdata[2*FB-1:FB];
    assign ld_weight = s_tdata[2*FB+mwbm_pkg::PAIR_BITS-1:2*FB];
    assign ld_wide   = 32'(signed'(ld_weight));
    assign ld_ok     = (32'(ld_row) < MAX_VERTICES) && (32'(ld_col) < MAX_VERTICES);
    assign waddr     = AW'(AW'(ld_row) * AW'(MAX_VERTICES) + AW'(ld_col));
    assign ram_we    = (op == mwbm_pkg::OP_LOAD) && ld_ok;

    always_comb
    begin
        priority if (size_reg == '0)
        begin
            n_cfg = CNT_W'(1);
        end
        else if (32'(size_reg) > MAX_VERTICES)
        begin
            n_cfg = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_cfg = CNT_W'(size_reg);
        end
    end

    assign rc_mode = (op == mwbm_pkg::OP_INIT_EV) || (op == mwbm_pkg::OP_SH_EV) ||
                     (op == mwbm_pkg::OP_OUT_RD) || (op == mwbm_pkg::OP_OUT_EV);
    assign lsel = rc_mode ? r_reg : x_reg;
    assign rsel = rc_mode ? c_reg : y_reg[IDX_W-1:0];
    assign partner_cur = partner_reg[rsel];
    assign pmatch = (partner_cur != '0);

    assign sidx = (op == mwbm_pkg::OP_AUG) ? k_reg : IDX_W'(depth_reg - CNT_W'(2));
    assign tidx = IDX_W'(depth_reg - CNT_W'(1));
    assign didx = IDX_W'(depth_reg);
    assign stack_rd = stack_reg[sidx];
    assign scan_rd  = scan_reg[sidx];
    assign nx = IDX_W'(partner_cur - CNT_W'(1));

    always_comb
    begin
        ram_re = 1'b0;
        raddr  = addr_of(r_reg, c_reg);
        unique case (op)
            mwbm_pkg::OP_INIT_RD, mwbm_pkg::OP_SH_RD:
            begin
                ram_re = 1'b1;
            end
            mwbm_pkg::OP_SCAN_RD:
            begin
                ram_re = 1'b1;
                raddr  = addr_of(x_reg, y_reg[IDX_W-1:0]);
            end
            mwbm_pkg::OP_OUT_RD:
            begin
                ram_re = 1'b1;
                raddr  = addr_of(nx, c_reg);
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    mwbm_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (ld_wide[WEIGHT_BITS-1:0]),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign w_ext     = LB'(rdata);
    assign max_new   = ((c_reg == '0) || (w_ext > max_reg)) ? w_ext : max_reg;
    assign lsum      = (LB+1)'(lx_reg[lsel]) + (LB+1)'(ly_reg[rsel]);
    assign slack     = SB'(lx_reg[lsel]) + SB'(ly_reg[rsel]) - SB'(w_ext);
    assign pw        = pmatch ? w_ext : '0;
    assign total_new = total_reg + TB'(pw);

    assign status.y_end     = (y_reg == n_reg);
    assign status.y_seen    = rseen_reg[rsel];
    assign status.eq        = (lsum == (LB+1)'(w_ext));
    assign status.free      = !pmatch;
    assign status.depth_one = (depth_reg == CNT_W'(1));
    assign status.k_last    = (CNT_W'(k_reg) == depth_reg - CNT_W'(1));
    assign status.root_last = (CNT_W'(root_reg) == n_reg - CNT_W'(1));
    assign status.col_last  = (CNT_W'(c_reg) == n_reg - CNT_W'(1));
    assign status.mat_last  = status.col_last && (CNT_W'(r_reg) == n_reg - CNT_W'(1));
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= mwbm_pkg::SIZE_RESET;
            n_reg         <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            x_reg         <= '0;
            root_reg      <= '0;
            k_reg         <= '0;
            y_reg         <= '0;
            depth_reg     <= '0;
            max_reg       <= '0;
            d_reg         <= '0;
            total_reg     <= '0;
            lseen_reg     <= '0;
            rseen_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                lx_reg[i]      <= '0;
                ly_reg[i]      <= '0;
                partner_reg[i] <= '0;
                stack_reg[i]   <= '0;
                scan_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            if (m_tready && (op != mwbm_pkg::OP_OUT_EV))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (op)
                mwbm_pkg::OP_START:
                begin
                    n_reg    <= n_cfg;
                    r_reg    <= '0;
                    c_reg    <= '0;
                    root_reg <= '0;
                    for (int i = 0; i < MAX_VERTICES; i++)
                    begin
                        partner_reg[i] <= '0;
                    end
                end
                mwbm_pkg::OP_INIT_EV:
                begin
                    max_reg <= max_new;
                    if (status.col_last)
                    begin
                        lx_reg[r_reg] <= max_new;
                        ly_reg[r_reg] <= '0;
                        c_reg         <= '0;
                        r_reg         <= r_reg + IDX_W'(1);
                    end
                    else
                    begin
                        c_reg <= c_reg + IDX_W'(1);
                    end
                end
                mwbm_pkg::OP_ROOT:
                begin
                    lseen_reg    <= MAX_VERTICES'(1) << root_reg;
                    rseen_reg    <= '0;
                    depth_reg    <= CNT_W'(1);
                    stack_reg[0] <= root_reg;
                    scan_reg[0]  <= '0;
                    x_reg        <= root_reg;
                    y_reg        <= '0;
                end
                mwbm_pkg::OP_NEXTY:
                begin
                    y_reg <= y_reg + CNT_W'(1);
                end
                mwbm_pkg::OP_EVAL:
                begin
                    if (!status.eq)
                    begin
                        y_reg <= y_reg + CNT_W'(1);
                    end
                    else
                    begin
                        rseen_reg[rsel] <= 1'b1;
                        scan_reg[tidx]  <= rsel;
                        if (!pmatch)
                        begin
                            k_reg <= '0;
                        end
                        else if (32'(depth_reg) < MAX_VERTICES)
                        begin
                            stack_reg[didx] <= nx;
                            scan_reg[didx]  <= '0;
                            lseen_reg[nx]   <= 1'b1;
                            depth_reg       <= depth_reg + CNT_W'(1);
                            x_reg           <= nx;
                            y_reg           <= '0;
                        end
                    end
                end
                mwbm_pkg::OP_POP:
                begin
                    depth_reg <= depth_reg - CNT_W'(1);
                    x_reg     <= stack_rd;
                    y_reg     <= CNT_W'(scan_rd);
                end
                mwbm_pkg::OP_AUG:
                begin
                    partner_reg[scan_rd] <= CNT_W'(stack_rd) + CNT_W'(1);
                    k_reg                <= k_reg + IDX_W'(1);
                end
                mwbm_pkg::OP_NEXT_ROOT:
                begin
                    root_reg  <= root_reg + IDX_W'(1);
                    c_reg     <= '0;
                    total_reg <= '0;
                end
                mwbm_pkg::OP_SH_START:
                begin
                    r_reg <= '0;
                    c_reg <= '0;
                    d_reg <= mwbm_pkg::SLACK_START;
                end
                mwbm_pkg::OP_SH_EV:
                begin
                    if (lseen_reg[lsel] && !rseen_reg[rsel] && (slack < d_reg))
                    begin
                        d_reg <= slack;
                    end
                    if (status.col_last)
                    begin
                        c_reg <= '0;
                        r_reg <= r_reg + IDX_W'(1);
                    end
                    else
                    begin
                        c_reg <= c_reg + IDX_W'(1);
                    end
                end
                mwbm_pkg::OP_SH_APPLY:
                begin
                    for (int i = 0; i < MAX_VERTICES; i++)
                    begin
                        if (lseen_reg[i])
                        begin
                            lx_reg[i] <= lx_reg[i] - LB'(d_reg);
                        end
                        if (rseen_reg[i])
                        begin
                            ly_reg[i] <= ly_reg[i] + LB'(d_reg);
                        end
                    end
                end
                mwbm_pkg::OP_OUT_EV:
                begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= {
                        4'b0000,
                        total_new,
                        pw[mwbm_pkg::PAIR_BITS-1:0],
                        pmatch ? FB'(nx) : FB'(0),
                        FB'(c_reg)
                    };
                    out_user_reg  <= pmatch;
                    out_last_reg  <= status.col_last;
                    total_reg     <= total_new;
                    c_reg         <= c_reg + IDX_W'(1);
                end
                default:
                begin
                    n_reg <= n_reg;
                end
            endcase
        end
    end

endmodule

// ===== sv/max_weight_bipartite_matching_unit.sv =====
// Top level of the max-weight bipartite matching unit: controller plus datapath.
//
// Load transactions (tuser 0) write one signed weight into the matrix store and are
// taken one per cycle while idle. A solve transaction (tuser 1) runs the Kuhn-Munkres
// search on the n-by-n corner of the store, n from the size register, then streams one
// result per right vertex in column order with tlast on the final one. Every weight read
// goes through the single registered read port of the matrix RAM, so each matrix step is
// a read state and an evaluate state: label setup visits all n*n entries, a search step
// reads and evaluates each examined column not yet on the path and skips one already on
// it, each backtrack and each augmenting path edge is a step of its own, every failed
// search adds a label shift over all n*n entries, and the result phase stalls while the
// sink holds off. A solve therefore takes data-dependent time. The unit accepts nothing
// while a solve runs; the size register is to be written by the user only while the
// unit is idle, and the block itself does not enforce this.
module max_weight_bipartite_matching_unit #(
    parameter int MAX_VERTICES = mwbm_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = mwbm_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // row[3:0], col[7:4], weight[23:8]
    input  logic [mwbm_pkg::IN_TDATA_BITS-1:0]  s_tdata,
    // req_type[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // right_index[3:0], left_index[7:4], pair_weight[23:8], total_weight[43:24], zero fill
    output logic [mwbm_pkg::OUT_TDATA_BITS-1:0] m_tdata,
    // matched[0]
    output logic                                m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [mwbm_pkg::SIZE_BITS-1:0]      cfg_wdata
);

    mwbm_pkg::op_t     op;
    mwbm_pkg::status_t status;
    logic              ready;

    mwbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (ready),
        .status   (status),
        .op       (op)
    );

    mwbm_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    assign s_tready = ready;

endmodule

// ===== bench/max_weight_bipartite_matching_unit_tb.sv =====
// Testbench for the max-weight bipartite matching unit: random loads and solves checked by a scoreboard.
`timescale 1ns / 1ps

typedef struct {
    logic [3:0]         right_idx;
    logic [3:0]         left_idx;
    logic               is_matched;
    logic signed [15:0] pair_w;
    logic signed [19:0] total_w;
    logic               final_flag;
} match_result_t;

class match_scoreboard;
    logic signed [15:0] weights[16][16];
    longint             lbl_left[16];
    longint             lbl_right[16];
    int unsigned        mate[16];
    bit                 seen_left[16];
    bit                 seen_right[16];
    int unsigned        path[16];
    int unsigned        resume[16];
    int unsigned        size_reg = 16;
    match_result_t      pending[$];
    int                 errors = 0;

    function bit augment_from(int unsigned root, int unsigned n);
        int unsigned depth;
        int unsigned top;
        int unsigned x;
        int unsigned y;
        int unsigned nx;
        bit          found;
        depth = 1;
        path[0] = root;
        resume[0] = 0;
        seen_left[root] = 1;
        while (depth > 0)
        begin
            top = depth - 1;
            x = path[top];
            y = resume[top];
            found = 0;
            while (y < n)
            begin
                if (!seen_right[y] && lbl_left[x] + lbl_right[y] == longint'(weights[x][y]))
                begin
                    found = 1;
                    break;
                end
                y++;
            end
            if (!found)
            begin
                depth--;
                continue;
            end
            seen_right[y] = 1;
            resume[top] = y;
            if (mate[y] == 0 || depth >= 16)
            begin
                if (mate[y] != 0)
                begin
                    resume[top] = y + 1;
                    continue;
                end
                for (int k = 0; k < depth; k++)
                    mate[resume[k]] = path[k] + 1;
                return 1;
            end
            nx = mate[y] - 1;
            path[depth] = nx;
            resume[depth] = 0;
            seen_left[nx] = 1;
            depth++;
        end
        return 0;
    endfunction

    function void shift_by_slack(int unsigned n);
        longint d;
        longint s;
        d = 64'h3f3f3f3f;
        for (int i = 0; i < n; i++)
            if (seen_left[i])
                for (int j = 0; j < n; j++)
                    if (!seen_right[j])
                    begin
                        s = lbl_left[i] + lbl_right[j] - longint'(weights[i][j]);
                        if (s < d)
                            d = s;
                    end
        for (int i = 0; i < n; i++)
        begin
            if (seen_left[i])
                lbl_left[i] -= d;
            if (seen_right[i])
                lbl_right[i] += d;
        end
    endfunction

    function void note_input(bit is_solve, logic [3:0] r, logic [3:0] c,
                             logic signed [15:0] w);
        int unsigned   n;
        longint        m;
        longint        total;
        match_result_t res;
        n = size_reg == 0 ? 1 : (size_reg > 16 ? 16 : size_reg);
        if (!is_solve)
        begin
            weights[r][c] = w;
            return;
        end
        for (int i = 0; i < n; i++)
        begin
            m = -64'h3f3f3f3f;
            lbl_right[i] = 0;
            for (int j = 0; j < n; j++)
                if (longint'(weights[i][j]) > m)
                    m = longint'(weights[i][j]);
            lbl_left[i] = m;
        end
        foreach (mate[i])
            mate[i] = 0;
        for (int i = 0; i < n; i++)
            forever
            begin
                foreach (seen_left[k])
                begin
                    seen_left[k] = 0;
                    seen_right[k] = 0;
                end
                if (augment_from(i, n))
                    break;
                shift_by_slack(n);
            end
        total = 0;
        for (int j = 0; j < n; j++)
        begin
            res.right_idx = 4'(j);
            res.final_flag = (j == n - 1);
            if (mate[j] != 0 && mate[j] <= n)
            begin
                res.left_idx = 4'(mate[j] - 1);
                res.is_matched = 1;
                res.pair_w = weights[mate[j] - 1][j];
                total += longint'(res.pair_w);
            end
            else
            begin
                res.left_idx = 4'd0;
                res.is_matched = 0;
                res.pair_w = 16'sd0;
            end
            res.total_w = 20'(total);
            pending.push_back(res);
        end
    endfunction

    function void check_result(logic [47:0] d, logic u, logic l);
        match_result_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result transaction tdata=%h", d);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (d[3:0] !== e.right_idx)
        begin
            $error("right_index exp %0d got %0d", e.right_idx, d[3:0]);
            errors++;
        end
        if (d[7:4] !== e.left_idx)
        begin
            $error("left_index exp %0d got %0d", e.left_idx, d[7:4]);
            errors++;
        end
        if (u !== e.is_matched)
        begin
            $error("matched exp %0d got %0d", e.is_matched, u);
            errors++;
        end
        if (d[23:8] !== e.pair_w)
        begin
            $error("pair_weight exp %0d got %0d", e.pair_w, $signed(d[23:8]));
            errors++;
        end
        if (d[43:24] !== e.total_w)
        begin
            $error("total_weight exp %0d got %0d", e.total_w, $signed(d[43:24]));
            errors++;
        end
        if (l !== e.final_flag)
        begin
            $error("last exp %0d got %0d", e.final_flag, l);
            errors++;
        end
    endfunction
endclass

module max_weight_bipartite_matching_unit_tb;

    localparam bit REQ_LOAD  = 1'b0;
    localparam bit REQ_SOLVE = 1'b1;

    logic                                clk = 0;
    logic                                rst_n = 0;
    logic                                s_tvalid = 0;
    logic                                s_tready;
    logic [mwbm_pkg::IN_TDATA_BITS-1:0]  s_tdata = '0;
    logic                                s_tuser = 0;
    logic                                m_tvalid;
    logic                                m_tready = 0;
    logic [mwbm_pkg::OUT_TDATA_BITS-1:0] m_tdata;
    logic                                m_tuser;
    logic                                m_tlast;
    logic                                cfg_we = 0;
    logic [mwbm_pkg::SIZE_BITS-1:0]      cfg_wdata = '0;

    match_scoreboard sb = new();
    int              items_sent = 0;
    bit              stim_done = 0;

    max_weight_bipartite_matching_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        #100_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [15:0] pick_weight(bit narrow);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'sh7fff;
        if (r == 1)
            return 16'sh8000;
        if (narrow)
            return 16'($urandom_range(0, 16)) - 16'd8;
        return 16'($urandom);
    endfunction

    task automatic send(bit req, logic [3:0] r, logic [3:0] c, logic signed [15:0] w,
                        bit bursty);
        int gap;
        gap = bursty ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= req;
        s_tdata  <= {w, c, r};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(req, r, c, w);
        items_sent++;
    endtask

    task automatic write_size(logic [mwbm_pkg::SIZE_BITS-1:0] v);
        @(negedge clk);
        s_tvalid  <= 0;
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 0;
        sb.size_reg = v;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 0;
        wait (sb.pending.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic load_corner(int n, bit narrow, bit bursty);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                send(REQ_LOAD, 4'(i), 4'(j), pick_weight(narrow), bursty);
    endtask

    initial
    begin
        int n;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // size 0 acts as one vertex; a load outside the corner is stored but unused
        // keep offering while the sink holds off so the unit fills and stalls
        write_size(5'd0);
        send(REQ_LOAD, 4'd15, 4'd15, 16'sh8000, 0);
        send(REQ_LOAD, 4'd0, 4'd0, 16'sh7fff, 0);
        send(REQ_SOLVE, 4'd0, 4'd0, 16'sd0, 0);
        send(REQ_SOLVE, 4'd0, 4'd0, 16'sd0, 0);
        send(REQ_LOAD, 4'd15, 4'd14, 16'sh0123, 0);
        send(REQ_SOLVE, 4'd0, 4'd0, 16'sd0, 0);
        drain();

        write_size(5'd1);
        send(REQ_LOAD, 4'd0, 4'd0, 16'sh8000, 0);
        send(REQ_SOLVE, 4'd15, 4'd15, 16'shffff, 0);
        drain();

        write_size(5'd2);
        send(REQ_LOAD, 4'd0, 4'd0, 16'sh7fff, 0);
        send(REQ_LOAD, 4'd0, 4'd1, 16'sh7fff, 0);
        send(REQ_LOAD, 4'd1, 4'd0, 16'sh8000, 0);
        send(REQ_LOAD, 4'd1, 4'd1, 16'sh8000, 0);
        send(REQ_SOLVE, 4'd0, 4'd0, 16'sd0, 0);
        drain();

        write_size(5'd16);
        load_corner(16, 1, 1);
        send(REQ_SOLVE, 4'd0, 4'd0, 16'sd0, 1);
        drain();

        // size above the maximum acts as the maximum
        write_size(5'd31);
        repeat (4)
            send(REQ_LOAD, 4'($urandom), 4'($urandom), pick_weight(0), 1);
        send(REQ_SOLVE, 4'($urandom), 4'($urandom), 16'($urandom), 1);
        drain();

        while (items_sent < 320)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 10) : $urandom_range(2, 6);
            write_size(5'(n));
            load_corner(n, 1'($urandom_range(0, 1)), 1);
            repeat ($urandom_range(0, 3))
                send(REQ_LOAD, 4'($urandom_range(n, 15)), 4'($urandom), pick_weight(0), 1);
            send(REQ_SOLVE, 4'($urandom), 4'($urandom), 16'($urandom), 1);
            if ($urandom_range(0, 2) == 0)
                send(REQ_SOLVE, 4'($urandom), 4'($urandom), 16'($urandom), 1);
            drain();
        end
        stim_done = 1;
    end

    initial
    begin
        int hold;
        int steady;
        @(posedge rst_n);
        // hold off the sink while the first solves queue up behind it
        m_tready <= 0;
        for (hold = 0; hold < 400; hold++)
            @(negedge clk);
        forever
        begin
            steady = $urandom_range(0, 1);
            repeat (50)
            begin
                @(negedge clk);
                if (steady)
                    m_tready <= 1;
                else if (m_tready && $urandom_range(0, 3) == 0)
                begin
                    m_tready <= 0;
                    hold = pick_gap();
                    repeat (hold) @(negedge clk);
                    m_tready <= 1;
                end
                else
                    m_tready <= 1;
            end
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);

    initial
    begin
        wait (stim_done);
        wait (sb.pending.size() == 0);
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
